// ===== design/cgs_pkg.sv =====
// Shared types, codes and helper functions for the checked group slot store.
// Used by cgs_lane, cgs_merge and checked_group_slot_store; depends on nothing.
package cgs_pkg;

    // Default table size and the number of blocks that a read covers.
    localparam int DEFAULT_NUM_BLOCKS = 8;
    localparam int READ_BLOCKS = 8;
    localparam logic [7:0] FRAME_LEN_BYTE = 8'h10;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_STORE = 2'd0,
        OP_DUP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // Status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CSUM    = 2'd1,
        ST_FULL    = 2'd2,
        ST_BAD_LEN = 2'd3
    } status_t;

    // Write command from the merge stage to one lane.
    typedef struct packed {
        logic       store_en;
        logic [1:0] grp_sel;
        logic       clear_en;
    } lane_cmd_t;

    // Summary that the merge stage hands to the top level.
    typedef struct packed {
        status_t    status;
        logic [3:0] free_before;
        logic [2:0] groups_stored;
        logic       duplicate;
    } merge_res_t;

    // Sum mod 256 of the four bytes of a word.
    function automatic logic [7:0] byte_sum32(input logic [31:0] w);
        byte_sum32 = w[7:0] + w[15:8] + w[23:16] + w[31:24];
    endfunction

    // Frame checksum: length byte plus the sixteen frame bytes, mod 256.
    function automatic logic [7:0] frame_sum16(input logic [63:0] lo, input logic [63:0] hi);
        frame_sum16 = FRAME_LEN_BYTE + byte_sum32(lo[31:0]) + byte_sum32(lo[63:32])
                      + byte_sum32(hi[31:0]) + byte_sum32(hi[63:32]);
    endfunction

endpackage

// ===== design/checked_group_slot_store.sv =====
// Checked group slot store, top level. Depends on cgs_pkg, cgs_lane, cgs_merge.
// The item is captured in S_IDLE, the lanes and merge stage evaluate in S_EVAL, and
// the first result is registered there and presented in S_SEND.
// One item at a time; the next item is accepted once the sequencer is back in
// S_IDLE after its last result is taken (two results for a read, one otherwise).
// All lanes evaluate in parallel, one lane per block, the merge stage assigns slots.
// Reset: asynchronous, clears every block (all free) and empties the output.
module checked_group_slot_store
    import cgs_pkg::*;
#(
    parameter int NUM_BLOCKS = DEFAULT_NUM_BLOCKS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [1:0]   operation,
    input  logic [7:0]   length,
    input  logic [63:0]  data_low,
    input  logic [63:0]  data_high,
    input  logic [7:0]   sum_byte,
    input  logic [2:0]   block_index,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [1:0]   status,
    output logic [3:0]   free_before,
    output logic [2:0]   groups_stored,
    output logic         duplicate,
    output logic         frame_number,
    output logic [63:0]  frame_low,
    output logic [63:0]  frame_high,
    output logic [7:0]   frame_sum,
    output logic         last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SEND
    } state_t;

    state_t       state_reg;
    op_t          op_reg;
    logic [7:0]   len_reg;
    logic [127:0] data_reg;
    logic [7:0]   sum_reg;
    logic [2:0]   idx_reg;

    logic         out_valid_reg;
    logic [1:0]   status_reg;
    logic [3:0]   free_before_reg;
    logic [2:0]   groups_reg;
    logic         dup_reg;
    logic         frame_num_reg;
    logic [63:0]  frame_low_reg;
    logic [63:0]  frame_high_reg;
    logic [7:0]   frame_sum_reg;
    logic         last_reg;

    logic [NUM_BLOCKS-1:0] free_vec;
    logic [NUM_BLOCKS-1:0] match_vec;
    logic [31:0]           lane_word [NUM_BLOCKS];
    lane_cmd_t             cmd [NUM_BLOCKS];
    merge_res_t            res;
    logic [31:0]           rd_word [READ_BLOCKS];
    logic [63:0]           f1_low;
    logic [63:0]           f1_high;

    // One lane per block.
    for (genvar b = 0; b < NUM_BLOCKS; b++)
    begin : g_lane
        cgs_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd[b]),
            .data_all   (data_reg),
            .block_word (lane_word[b]),
            .is_free    (free_vec[b]),
            .is_match   (match_vec[b])
        );
    end

    // Merge of the lane findings.
    cgs_merge #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_merge (
        .active      (state_reg == S_EVAL),
        .operation   (op_reg),
        .length      (len_reg),
        .data_all    (data_reg),
        .sum_byte    (sum_reg),
        .block_index (idx_reg),
        .free_vec    (free_vec),
        .match_vec   (match_vec),
        .res         (res),
        .cmd         (cmd)
    );

    // Read-out words; blocks beyond the table read as zero.
    for (genvar i = 0; i < READ_BLOCKS; i++)
    begin : g_rd
        if (i < NUM_BLOCKS)
        begin : g_have
            assign rd_word[i] = lane_word[i];
        end
        else
        begin : g_none
            assign rd_word[i] = 32'd0;
        end
    end

    assign f1_low  = {rd_word[5], rd_word[4]};
    assign f1_high = {rd_word[7], rd_word[6]};

    // Sequencer with input capture and registered results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_STORE;
            len_reg         <= '0;
            data_reg        <= '0;
            sum_reg         <= '0;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= '0;
            free_before_reg <= '0;
            groups_reg      <= '0;
            dup_reg         <= 1'b0;
            frame_num_reg   <= 1'b0;
            frame_low_reg   <= '0;
            frame_high_reg  <= '0;
            frame_sum_reg   <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= op_t'(operation);
                        len_reg   <= length;
                        data_reg  <= {data_high, data_low};
                        sum_reg   <= sum_byte;
                        idx_reg   <= block_index;
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    out_valid_reg   <= 1'b1;
                    status_reg      <= res.status;
                    free_before_reg <= res.free_before;
                    groups_reg      <= res.groups_stored;
                    dup_reg         <= res.duplicate;
                    frame_num_reg   <= 1'b0;
                    if (op_reg == OP_READ)
                    begin
                        frame_low_reg  <= {rd_word[1], rd_word[0]};
                        frame_high_reg <= {rd_word[3], rd_word[2]};
                        frame_sum_reg  <= frame_sum16({rd_word[1], rd_word[0]},
                                                      {rd_word[3], rd_word[2]});
                        last_reg       <= 1'b0;
                    end
                    else
                    begin
                        frame_low_reg  <= '0;
                        frame_high_reg <= '0;
                        frame_sum_reg  <= '0;
                        last_reg       <= 1'b1;
                    end
                    state_reg <= S_SEND;
                end
                S_SEND:
                begin
                    if (!out_stall)
                    begin
                        if (last_reg)
                        begin
                            out_valid_reg <= 1'b0;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            // Second frame of a read.
                            frame_num_reg  <= 1'b1;
                            frame_low_reg  <= f1_low;
                            frame_high_reg <= f1_high;
                            frame_sum_reg  <= frame_sum16(f1_low, f1_high);
                            last_reg       <= 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Port drive.
    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign free_before   = free_before_reg;
    assign groups_stored = groups_reg;
    assign duplicate     = dup_reg;
    assign frame_number  = frame_num_reg;
    assign frame_low     = frame_low_reg;
    assign frame_high    = frame_high_reg;
    assign frame_sum     = frame_sum_reg;
    assign last          = last_reg;

endmodule

// ===== design/cgs_lane.sv =====
// One lane of the store: holds a single 32-bit block and tests it.
// Depends on cgs_pkg for the lane command type.
module cgs_lane
    import cgs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  lane_cmd_t    cmd,
    input  logic [127:0] data_all,
    output logic [31:0]  block_word,
    output logic         is_free,
    output logic         is_match
);

    logic [31:0] block_reg;
    logic [31:0] block_next;

    // Pick the group assigned to this block, or clear it.
    always_comb
    begin
        block_next = block_reg;
        if (cmd.store_en)
        begin
            block_next = data_all[32 * cmd.grp_sel +: 32];
        end
        else if (cmd.clear_en)
        begin
            block_next = '0;
        end
    end

    // Block storage; reset leaves the block free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_reg <= '0;
        end
        else
        begin
            block_reg <= block_next;
        end
    end

    // Per-block findings for the merge stage.
    assign block_word = block_reg;
    assign is_free    = (block_reg == 32'd0);
    assign is_match   = (block_reg == data_all[31:0]);

endmodule

// ===== design/cgs_merge.sv =====
// Merge stage: combines the lanes' free and match bits, checks the frame,
// and assigns groups to free blocks in ascending order. Depends on cgs_pkg.
module cgs_merge
    import cgs_pkg::*;
#(
    parameter int NUM_BLOCKS = DEFAULT_NUM_BLOCKS
)
(
    input  logic                  active,
    input  op_t                   operation,
    input  logic [7:0]            length,
    input  logic [127:0]          data_all,
    input  logic [7:0]            sum_byte,
    input  logic [2:0]            block_index,
    input  logic [NUM_BLOCKS-1:0] free_vec,
    input  logic [NUM_BLOCKS-1:0] match_vec,
    output merge_res_t            res,
    output lane_cmd_t             cmd [NUM_BLOCKS]
);

    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    logic [2:0]       groups;
    logic [7:0]       csum;
    logic [CNT_W-1:0] nfree;
    logic [CNT_W-1:0] rank [NUM_BLOCKS];
    status_t          status;

    // Group count from the length byte; zero marks a bad length.
    always_comb
    begin
        if (length == 8'd1)
        begin
            groups = 3'd1;
        end
        else if (length == 8'd4 || length == 8'd8 || length == 8'd12 || length == 8'd16)
        begin
            groups = length[4:2];
        end
        else
        begin
            groups = 3'd0;
        end
    end

    // Checksum over the length byte and the groups in use.
    always_comb
    begin
        csum = length;
        for (int g = 0; g < 4; g++)
        begin
            if (3'(g) < groups)
            begin
                csum = csum + byte_sum32(data_all[32 * g +: 32]);
            end
        end
    end

    // Free count and, for each lane, the number of free blocks below it.
    always_comb
    begin
        nfree = '0;
        for (int b = 0; b < NUM_BLOCKS; b++)
        begin
            nfree = nfree + CNT_W'(free_vec[b]);
        end
        for (int b = 0; b < NUM_BLOCKS; b++)
        begin
            rank[b] = '0;
            for (int j = 0; j < NUM_BLOCKS; j++)
            begin
                if (j < b)
                begin
                    rank[b] = rank[b] + CNT_W'(free_vec[j]);
                end
            end
        end
    end

    // Store checks in order: length, checksum, then room in the table.
    always_comb
    begin
        if (groups == 3'd0)
        begin
            status = ST_BAD_LEN;
        end
        else if (csum != sum_byte)
        begin
            status = ST_CSUM;
        end
        else if (nfree == '0)
        begin
            status = ST_FULL;
        end
        else
        begin
            status = ST_OK;
        end
    end

    // Result summary.
    always_comb
    begin
        res.status      = (operation == OP_STORE) ? status : ST_OK;
        res.free_before = (int'(nfree) > 15) ? 4'd15 : 4'(nfree);
        res.duplicate   = (operation == OP_DUP) ? (|match_vec) : 1'b0;
        if (operation == OP_STORE && status == ST_OK)
        begin
            res.groups_stored = (nfree < CNT_W'(groups)) ? 3'(nfree) : groups;
        end
        else
        begin
            res.groups_stored = 3'd0;
        end
        if (operation != OP_STORE)
        begin
            res.free_before = 4'd0;
        end
    end

    // Write commands for the lanes.
    always_comb
    begin
        for (int b = 0; b < NUM_BLOCKS; b++)
        begin
            cmd[b].store_en = active && (operation == OP_STORE) && (status == ST_OK)
                              && free_vec[b] && (rank[b] < CNT_W'(groups));
            cmd[b].grp_sel  = rank[b][1:0];
            cmd[b].clear_en = active && (operation == OP_CLEAR)
                              && (int'(block_index) == b);
        end
    end

endmodule

// ===== tb/sv/checked_group_slot_store_test.sv =====
// Self-checking testbench for checked_group_slot_store: directed rows, then random items.
// Keeps its own copy of the block table to predict every result.
// Depends on cgs_pkg and the checked_group_slot_store RTL.
module checked_group_slot_store_test;
    import cgs_pkg::*;

    localparam int DIRECTED_ROWS = 24;
    localparam int RANDOM_PER_PHASE = 475;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam logic [63:0] ONES64 = {64{1'b1}};

    // One result item of the block.
    typedef struct packed {
        status_t     status;
        logic [3:0]  free_before;
        logic [2:0]  groups_stored;
        logic        duplicate;
        logic        frame_number;
        logic [63:0] frame_low;
        logic [63:0] frame_high;
        logic [7:0]  frame_sum;
        logic        last;
    } result_t;

    // One input item, plus a typed-in answer for rows whose result is obvious.
    typedef struct packed {
        op_t         op;
        logic [7:0]  len;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [7:0]  sum;
        logic        auto_sum;
        logic [2:0]  idx;
        logic        typed;
        status_t     t_status;
        logic [3:0]  t_free;
        logic [2:0]  t_groups;
        logic        t_dup;
    } plan_row_t;

    logic         clk;
    logic         rst_n;
    logic         in_valid;
    logic         in_stall;
    logic [1:0]   operation;
    logic [7:0]   length;
    logic [63:0]  data_low;
    logic [63:0]  data_high;
    logic [7:0]   sum_byte;
    logic [2:0]   block_index;
    logic         out_valid;
    logic         out_stall;
    logic [1:0]   status;
    logic [3:0]   free_before;
    logic [2:0]   groups_stored;
    logic         duplicate;
    logic         frame_number;
    logic [63:0]  frame_low;
    logic [63:0]  frame_high;
    logic [7:0]   frame_sum;
    logic         last;

    logic [31:0]  slot_copy [8];
    result_t      awaited_results [$];
    plan_row_t    directed_plan [DIRECTED_ROWS];
    int           mismatch_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           quiet_cycles;

    checked_group_slot_store u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .length        (length),
        .data_low      (data_low),
        .data_high     (data_high),
        .sum_byte      (sum_byte),
        .block_index   (block_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .free_before   (free_before),
        .groups_stored (groups_stored),
        .duplicate     (duplicate),
        .frame_number  (frame_number),
        .frame_low     (frame_low),
        .frame_high    (frame_high),
        .frame_sum     (frame_sum),
        .last          (last)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Data group g is data bytes 4g..4g+3.
    function automatic logic [31:0] group_word(input logic [63:0] lo, input logic [63:0] hi,
                                               input int g);
        if (g < 2)
            return lo[32*g +: 32];
        else
            return hi[32*(g-2) +: 32];
    endfunction

    // Sum of the four bytes of a block, mod 256.
    function automatic logic [7:0] word_byte_total(input logic [31:0] w);
        return w[7:0] + w[15:8] + w[23:16] + w[31:24];
    endfunction

    // Number of groups that a length byte carries; zero means the length is refused.
    function automatic int groups_in_length(input logic [7:0] len);
        if (len == 8'd1)
            return 1;
        else if (len == 8'd4 || len == 8'd8 || len == 8'd12 || len == 8'd16)
            return len / 4;
        else
            return 0;
    endfunction

    // Checksum that a well-formed store must carry.
    function automatic logic [7:0] store_checksum(input logic [7:0] len, input logic [63:0] lo,
                                                  input logic [63:0] hi);
        logic [7:0] acc;
        int         n;
        acc = len;
        n = groups_in_length(len);
        for (int g = 0; g < n; g++)
            acc = acc + word_byte_total(group_word(lo, hi, g));
        return acc;
    endfunction

    // Applies one accepted item to the table copy and queues the results it causes.
    task automatic compute_slot_results(input plan_row_t item);
        result_t     r;
        int          free_cnt;
        int          ngroups;
        int          stored;
        logic [31:0] w [4];
        logic [7:0]  fsum;
        r = '0;
        r.last = 1'b1;
        free_cnt = 0;
        stored = 0;
        for (int b = 0; b < 8; b++)
            if (slot_copy[b] == 32'd0)
                free_cnt++;
        case (item.op)
            OP_STORE:
            begin
                ngroups = groups_in_length(item.len);
                if (ngroups == 0)
                    r.status = ST_BAD_LEN;
                else if (store_checksum(item.len, item.lo, item.hi) != item.sum)
                    r.status = ST_CSUM;
                else if (free_cnt == 0)
                    r.status = ST_FULL;
                else
                begin
                    // Groups go to free blocks in ascending order until either runs out.
                    for (int b = 0; b < 8 && stored < ngroups; b++)
                    begin
                        if (slot_copy[b] == 32'd0)
                        begin
                            slot_copy[b] = group_word(item.lo, item.hi, stored);
                            stored++;
                        end
                    end
                end
                r.free_before = 4'(free_cnt);
                r.groups_stored = 3'(stored);
                awaited_results.push_back(r);
            end
            OP_DUP:
            begin
                for (int b = 0; b < 8; b++)
                    if (slot_copy[b] == item.lo[31:0])
                        r.duplicate = 1'b1;
                awaited_results.push_back(r);
            end
            OP_CLEAR:
            begin
                slot_copy[item.idx] = 32'd0;
                awaited_results.push_back(r);
            end
            default:
            begin
                // A read gives two frames of four blocks each.
                for (int k = 0; k < 2; k++)
                begin
                    fsum = FRAME_LEN_BYTE;
                    for (int j = 0; j < 4; j++)
                    begin
                        w[j] = slot_copy[4*k + j];
                        fsum = fsum + word_byte_total(w[j]);
                    end
                    r = '0;
                    r.frame_number = 1'(k);
                    r.frame_low = {w[1], w[0]};
                    r.frame_high = {w[3], w[2]};
                    r.frame_sum = fsum;
                    r.last = (k == 1);
                    awaited_results.push_back(r);
                end
            end
        endcase
    endtask

    // Random item, mostly well-formed, biased toward clears when the table fills up.
    function automatic plan_row_t draw_random_item();
        plan_row_t it;
        int        pick;
        int        free_cnt;
        int        store_pct;
        int        k;
        it = '0;
        it.lo = {$urandom, $urandom};
        it.hi = {$urandom, $urandom};
        it.len = 8'($urandom_range(0, 255));
        it.sum = 8'($urandom_range(0, 255));
        it.idx = 3'($urandom_range(0, 7));
        free_cnt = 0;
        for (int b = 0; b < 8; b++)
            if (slot_copy[b] == 32'd0)
                free_cnt++;
        store_pct = (free_cnt <= 2) ? 20 : 50;
        pick = $urandom_range(0, 99);
        if (pick < store_pct)
        begin
            it.op = OP_STORE;
            if ($urandom_range(0, 99) < 85)
            begin
                k = $urandom_range(0, 4);
                it.len = (k == 0) ? 8'd1 : 8'(4 * k);
            end
            it.auto_sum = ($urandom_range(0, 99) < 85);
            // Zero groups are written but leave their block free.
            for (int g = 0; g < 2; g++)
            begin
                if ($urandom_range(0, 99) < 12)
                    it.lo[32*g +: 32] = 32'd0;
                if ($urandom_range(0, 99) < 12)
                    it.hi[32*g +: 32] = 32'd0;
            end
        end
        else if (pick < store_pct + 15)
        begin
            it.op = OP_DUP;
            k = $urandom_range(0, 99);
            if (k < 50)
                it.lo[31:0] = slot_copy[3'($urandom_range(0, 7))];
            else if (k < 65)
                it.lo[31:0] = 32'd0;
        end
        else if (pick < store_pct + 30)
            it.op = OP_READ;
        else
            it.op = OP_CLEAR;
        return it;
    endfunction

    // Presents one item, waits for it to be taken and records what it should produce.
    task automatic send_item(input plan_row_t item);
        result_t typed_res;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        if (item.auto_sum)
            item.sum = store_checksum(item.len, item.lo, item.hi);
        operation = item.op;
        length = item.len;
        data_low = item.lo;
        data_high = item.hi;
        sum_byte = item.sum;
        block_index = item.idx;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        compute_slot_results(item);
        // Typed-in answers stand in for the predicted one; the table copy still advances.
        if (item.typed)
        begin
            typed_res = '0;
            typed_res.status = item.t_status;
            typed_res.free_before = item.t_free;
            typed_res.groups_stored = item.t_groups;
            typed_res.duplicate = item.t_dup;
            typed_res.last = 1'b1;
            awaited_results[awaited_results.size() - 1] = typed_res;
        end
        @(negedge clk);
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // Receiver stalls at random.
    always @(negedge clk)
        out_stall = ($urandom_range(0, 99) < recv_idle_pct);

    // Each taken result is compared with the oldest outstanding one.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result with nothing outstanding, actual status %0h frame %0h",
                         $time, status, frame_number);
                mismatch_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("status", 64'(want.status), 64'(status));
                check_field("free_before", 64'(want.free_before), 64'(free_before));
                check_field("groups_stored", 64'(want.groups_stored), 64'(groups_stored));
                check_field("duplicate", 64'(want.duplicate), 64'(duplicate));
                check_field("frame_number", 64'(want.frame_number), 64'(frame_number));
                check_field("frame_low", want.frame_low, frame_low);
                check_field("frame_high", want.frame_high, frame_high);
                check_field("frame_sum", 64'(want.frame_sum), 64'(frame_sum));
                check_field("last", 64'(want.last), 64'(last));
            end
        end
    end

    // Watchdog: too long without any item moving ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("checked_group_slot_store_test: errors");
            $finish;
        end
    end

    // Directed rows: reset state, length and checksum errors, a full table, clears and reads.
    initial
    begin
        directed_plan[0]  = '{OP_READ, 8'd0, 64'd0, 64'd0, 8'd0, 1'b0, 3'd0,
                              1'b0, ST_OK, 4'd0, 3'd0, 1'b0};
        directed_plan[1]  = '{OP_DUP, 8'd0, 64'd0, 64'd0, 8'd0, 1'b0, 3'd0,
                              1'b1, ST_OK, 4'd0, 3'd0, 1'b1};
        directed_plan[2]  = '{OP_DUP, 8'd0, ONES64, ONES64, 8'd0, 1'b0, 3'd0,
                              1'b1, ST_OK, 4'd0, 3'd0, 1'b0};
        directed_plan[3]  = '{OP_STORE, 8'd0, 64'd0, 64'd0, 8'd0, 1'b0, 3'd0,
                              1'b1, ST_BAD_LEN, 4'd8, 3'd0, 1'b0};
        directed_plan[4]  = '{OP_STORE, 8'hFF, ONES64, ONES64, 8'hFF, 1'b0, 3'd7,
                              1'b1, ST_BAD_LEN, 4'd8, 3'd0, 1'b0};
        directed_plan[5]  = '{OP_STORE, 8'd2, 64'h0102, 64'd0, 8'd5, 1'b0, 3'd0,
                              1'b1, ST_BAD_LEN, 4'd8, 3'd0, 1'b0};
        directed_plan[6]  = '{OP_STORE, 8'd16, ONES64, ONES64, 8'h01, 1'b0, 3'd0,
                              1'b1, ST_CSUM, 4'd8, 3'd0, 1'b0};
        // Length one carries one group; the upper bytes do not enter the checksum.
        directed_plan[7]  = '{OP_STORE, 8'd1, 64'h0123_4567_A5A5_A5A5, 64'h89AB_CDEF_0000_0001,
                              8'd0, 1'b1, 3'd0, 1'b0, ST_OK, 4'd0, 3'd0, 1'b0};
        directed_plan[8]  = '{OP_STORE, 8'd16, ONES64, ONES64, 8'd0, 1'b1, 3'd0,
                              1'b0, ST_OK, 4'd0, 3'd0, 1'b0};
        // A zero group is written and its block stays free.
        directed_plan[9]  = '{OP_STORE, 8'd4, 64'h5555_5555_0000_0000, 64'h1, 8'd0, 1'b1, 3'd0,
                              1'b0, ST_OK, 4'd0, 3'd0, 1'b0};
        directed_plan[10] = '{OP_STORE, 8'd8, 64'h8000_0001_0000_0080, 64'd0, 8'd0, 1'b1, 3'd0,
                              1'b0, ST_OK, 4'd0, 3'd0, 1'b0};
        // Only one block is left, so three groups become a partial write.
        directed_plan[11] = '{OP_STORE, 8'd12, 64'h7F7F_7F7F_0102_0304, 64'hAAAA_AAAA_5555_5555,
                              8'd0, 1'b1, 3'd0, 1'b0, ST_OK, 4'd0, 3'd0, 1'b0};
        directed_plan[12] = '{OP_STORE, 8'd4, 64'h11, 64'd0, 8'd0, 1'b1, 3'd0,
                              1'b1, ST_FULL, 4'd0, 3'd0, 1'b0};
        // The checksum is checked ahead of the full table.
        directed_plan[13] = '{OP_STORE, 8'd8, 64'h1, 64'd0, 8'd0, 1'b0, 3'd0,
                              1'b1, ST_CSUM, 4'd0, 3'd0, 1'b0};
        directed_plan[14] = '{OP_DUP, 8'd0, 64'hFFFF_FFFF, 64'd0, 8'd0, 1'b0, 3'd0,
                              1'b1, ST_OK, 4'd0, 3'd0, 1'b1};
        directed_plan[15] = '{OP_DUP, 8'd0, 64'd0, 64'd0, 8'd0, 1'b0, 3'd0,
                              1'b1, ST_OK, 4'd0, 3'd0, 1'b0};
        directed_plan[16] = '{OP_READ, 8'd0, 64'd0, 64'd0, 8'd0, 1'b0, 3'd0,
                              1'b0, ST_OK, 4'd0, 3'd0, 1'b0};
        directed_plan[17] = '{OP_CLEAR, 8'd0, 64'd0, 64'd0, 8'd0, 1'b0, 3'd0,
                              1'b1, ST_OK, 4'd0, 3'd0, 1'b0};
        directed_plan[18] = '{OP_CLEAR, 8'd0, 64'd0, 64'd0, 8'd0, 1'b0, 3'd7,
                              1'b1, ST_OK, 4'd0, 3'd0, 1'b0};
        directed_plan[19] = '{OP_DUP, 8'd0, 64'd0, 64'd0, 8'd0, 1'b0, 3'd0,
                              1'b1, ST_OK, 4'd0, 3'd0, 1'b1};
        directed_plan[20] = '{OP_STORE, 8'd16, 64'hDEAD_BEEF_CAFE_F00D, 64'h0000_0000_1234_5678,
                              8'd0, 1'b1, 3'd0, 1'b0, ST_OK, 4'd0, 3'd0, 1'b0};
        directed_plan[21] = '{OP_CLEAR, 8'd0, 64'd0, 64'd0, 8'd0, 1'b0, 3'd3,
                              1'b1, ST_OK, 4'd0, 3'd0, 1'b0};
        directed_plan[22] = '{OP_CLEAR, 8'd0, 64'd0, 64'd0, 8'd0, 1'b0, 3'd3,
                              1'b1, ST_OK, 4'd0, 3'd0, 1'b0};
        directed_plan[23] = '{OP_READ, 8'd0, 64'd0, 64'd0, 8'd0, 1'b0, 3'd0,
                              1'b0, ST_OK, 4'd0, 3'd0, 1'b0};
    end

    // Main sequence: reset, directed rows, three random phases, drain, verdict.
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_STORE;
        length = 8'd0;
        data_low = 64'd0;
        data_high = 64'd0;
        sum_byte = 8'd0;
        block_index = 3'd0;
        send_idle_pct = 10;
        recv_idle_pct = 80;
        for (int b = 0; b < 8; b++)
            slot_copy[b] = 32'd0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_item(directed_plan[i]);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 80 : 0;
            recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 10 : 0;
            repeat (RANDOM_PER_PHASE)
                send_item(draw_random_item());
        end
        in_valid = 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("checked_group_slot_store_test: clean");
        else
            $display("checked_group_slot_store_test: errors");
        $finish;
    end

endmodule
